FILE: hw/rtl/lgs_pkg.sv
// shared types, constants and codes for the life generation step block
// no dependencies; imported by life_generation_step, lgs_row_rule and the bench

package lgs_pkg;

  // widths fixed by the item and register fields
  localparam int SIZE_W      = 8;
  localparam int COL_FIELD_W = 7;
  localparam int ROW_FIELD_W = 7;
  localparam int MODE_W      = 2;

  // wide enough for any size or counter up to 1024 + 2
  localparam int XW = 11;

  // default grid bounds
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 128;

  // register reset values and the smallest legal size
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd100;
  localparam logic [XW-1:0]     SIZE_MIN   = 11'd3;

  // neighbourhood counts, centre included
  localparam logic [3:0] BIRTH_COUNT     = 4'd3;
  localparam logic [3:0] KEEP_COUNT_LOW  = 4'd3;
  localparam logic [3:0] KEEP_COUNT_HIGH = 4'd4;

  // configuration register indexes
  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_t;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [COL_FIELD_W-1:0] cell_column;
    logic [ROW_FIELD_W-1:0] cell_row;
    logic                   write_alive;
  } lgs_in_t;

  typedef struct packed {
    logic read_alive;
    logic done_res;
  } lgs_out_t;

endpackage

FILE: hw/rtl/life_generation_step.sv
// top level of the toroidal b3/s23 life grid: sequencer, config registers, result register
// depends on lgs_pkg, lgs_row_ram and lgs_row_rule

// usage
//   input beats (in_valid / in_stall / in_data) carry a mode and a cell position:
//   write one cell, read one cell, or advance the active grid by one generation
//   every input beat gives exactly one output beat on out_valid / out_stall / out_data
//   the grid is held one row per memory word; a generation sweeps the rows through
//   a three-row window, writes new rows to a scratch memory, then copies them back
//   an in-range read or write passes through a cell read and a write-back state to
//   the finishing state; an out-of-range cell or the unused mode goes there at once;
//   a generation reads one row per cycle, from the grid memory, then the scratch one
//   one item is in work at a time; the next is taken once its result sits in the
//   output register, even while that register is still stalled
//   after reset the grid memory is cleared one row a cycle, all MAX_ROWS rows, with
//   in_stall high; config writes are taken during that time as ever
//   config (cfg_we, cfg_index, cfg_wdata) should only be written while idle
//   a stalled output beat holds; the sequencer waits in its last state if the
//   output register is still full when the next result is ready

module life_generation_step
  import lgs_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lgs_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lgs_out_t          out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam int CIDX_W = $clog2(MAX_COLUMNS);
  localparam int RIDX_W = $clog2(MAX_ROWS);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CELL_RD = 7'b0000100,
    S_CELL_WB = 7'b0001000,
    S_SWEEP   = 7'b0010000,
    S_COPY    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   cols_reg_r, rows_reg_r;
  logic [RIDX_W-1:0]   clr_r, clr_nxt;
  logic [RIDX_W-1:0]   addr_r, addr_nxt;
  logic [XW-1:0]       iss_r, iss_nxt;
  logic [XW-1:0]       rcv_r, rcv_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [XW-1:0]       cp_iss_r, cp_iss_nxt;
  logic                cp_vld_r, cp_vld_nxt;
  logic [RIDX_W-1:0]   cp_wa_r, cp_wa_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload
  lgs_in_t             item_r, item_nxt;
  logic                res_r, res_nxt;
  logic [MAX_COLUMNS-1:0] up_r, up_nxt, mid_r, mid_nxt;
  lgs_out_t            out_data_r, out_data_nxt;

  // memory ports
  logic                   cell_we, cell_re, nxt_we, nxt_re;
  logic [RIDX_W-1:0]      cell_waddr, cell_raddr, nxt_waddr, nxt_raddr;
  logic [MAX_COLUMNS-1:0] cell_wdata, cell_rdata, nxt_wdata, nxt_rdata;
  logic [MAX_COLUMNS-1:0] new_row, mod_row;

  // active sizes, clamped to the legal range
  logic [XW-1:0] cols_x, rows_x, cols_eff, rows_eff;

  assign cols_x = XW'(cols_reg_r);
  assign rows_x = XW'(rows_reg_r);

  always_comb begin
    if (cols_x < SIZE_MIN) begin
      cols_eff = SIZE_MIN;
    end else if (cols_x > XW'(MAX_COLUMNS)) begin
      cols_eff = XW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_x;
    end
    if (rows_x < SIZE_MIN) begin
      rows_eff = SIZE_MIN;
    end else if (rows_x > XW'(MAX_ROWS)) begin
      rows_eff = XW'(MAX_ROWS);
    end else begin
      rows_eff = rows_x;
    end
  end

  // position checks on the incoming beat and on the held item
  logic [XW-1:0]     in_col_x, in_row_x, col_x, row_x;
  logic              in_inside;
  logic [CIDX_W-1:0] cidx;
  logic [RIDX_W-1:0] ridx;

  assign in_col_x  = XW'(in_data.cell_column);
  assign in_row_x  = XW'(in_data.cell_row);
  assign in_inside = (in_col_x < cols_eff) && (in_row_x < rows_eff);
  assign col_x     = XW'(item_r.cell_column);
  assign row_x     = XW'(item_r.cell_row);
  assign cidx      = col_x[CIDX_W-1:0];
  assign ridx      = row_x[RIDX_W-1:0];

  // single-cell update of the row just read
  always_comb begin
    mod_row       = cell_rdata;
    mod_row[cidx] = item_r.write_alive;
  end

  // sweep progress
  logic          sweep_issue, copy_issue, sweep_last, copy_last;
  logic [XW-1:0] rcv_m2;

  assign sweep_issue = (iss_r < (rows_eff + XW'(2)));
  assign copy_issue  = (cp_iss_r < rows_eff);
  assign sweep_last  = rd_vld_r && (rcv_r == (rows_eff + XW'(1)));
  assign copy_last   = cp_vld_r && (XW'(cp_wa_r) == (rows_eff - XW'(1)));
  assign rcv_m2      = rcv_r - XW'(2);

  lgs_row_rule #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_rule (
    .up_row  (up_r),
    .mid_row (mid_r),
    .down_row(cell_rdata),
    .cols    (cols_eff),
    .new_row (new_row)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    iss_nxt       = iss_r;
    rcv_nxt       = rcv_r;
    rd_vld_nxt    = 1'b0;
    cp_iss_nxt    = cp_iss_r;
    cp_vld_nxt    = 1'b0;
    cp_wa_nxt     = cp_wa_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    cell_we    = 1'b0;
    cell_waddr = ridx;
    cell_wdata = mod_row;
    cell_re    = 1'b0;
    cell_raddr = ridx;
    nxt_we     = 1'b0;
    nxt_waddr  = rcv_m2[RIDX_W-1:0];
    nxt_wdata  = new_row;
    nxt_re     = 1'b0;
    nxt_raddr  = cp_iss_r[RIDX_W-1:0];

    case (state_r)
      S_CLEAR: begin
        // zero one grid row a cycle
        cell_we    = 1'b1;
        cell_waddr = clr_r;
        cell_wdata = '0;
        clr_nxt    = clr_r + RIDX_W'(1);
        if (clr_r == RIDX_W'(MAX_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        addr_nxt   = RIDX_W'(rows_eff - XW'(1));
        iss_nxt    = '0;
        rcv_nxt    = '0;
        cp_iss_nxt = '0;
        res_nxt    = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.mode)
            MODE_WRITE, MODE_READ: begin
              state_nxt = in_inside ? S_CELL_RD : S_FINISH;
            end
            MODE_STEP: begin
              state_nxt = S_SWEEP;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_CELL_RD: begin
        cell_re   = 1'b1;
        state_nxt = S_CELL_WB;
      end
      S_CELL_WB: begin
        if (item_r.mode == MODE_WRITE) begin
          cell_we = 1'b1;
        end
        res_nxt   = (item_r.mode == MODE_READ) ? cell_rdata[cidx] : 1'b0;
        state_nxt = S_FINISH;
      end
      S_SWEEP: begin
        // rows are read last, 0, 1, ... last, 0 so every window has both neighbours
        if (sweep_issue) begin
          cell_re    = 1'b1;
          cell_raddr = addr_r;
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + XW'(1);
          addr_nxt   = (XW'(addr_r) == (rows_eff - XW'(1))) ? '0 : addr_r + RIDX_W'(1);
        end
        if (rd_vld_r) begin
          up_nxt  = mid_r;
          mid_nxt = cell_rdata;
          rcv_nxt = rcv_r + XW'(1);
          if (rcv_r >= XW'(2)) begin
            nxt_we = 1'b1;
          end
        end
        if (sweep_last) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // new generation replaces the active rows
        if (copy_issue) begin
          nxt_re     = 1'b1;
          cp_vld_nxt = 1'b1;
          cp_wa_nxt  = cp_iss_r[RIDX_W-1:0];
          cp_iss_nxt = cp_iss_r + XW'(1);
        end
        if (cp_vld_r) begin
          cell_we    = 1'b1;
          cell_waddr = cp_wa_r;
          cell_wdata = nxt_rdata;
        end
        if (copy_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_alive = res_r;
          out_data_nxt.done_res   = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  lgs_row_ram #(
    .DEPTH(MAX_ROWS),
    .WIDTH(MAX_COLUMNS)
  ) u_cell_mem (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .re   (cell_re),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  lgs_row_ram #(
    .DEPTH(MAX_ROWS),
    .WIDTH(MAX_COLUMNS)
  ) u_next_mem (
    .clk  (clk),
    .we   (nxt_we),
    .waddr(nxt_waddr),
    .wdata(nxt_wdata),
    .re   (nxt_re),
    .raddr(nxt_raddr),
    .rdata(nxt_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      addr_r      <= '0;
      iss_r       <= '0;
      rcv_r       <= '0;
      rd_vld_r    <= 1'b0;
      cp_iss_r    <= '0;
      cp_vld_r    <= 1'b0;
      cp_wa_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      addr_r      <= addr_nxt;
      iss_r       <= iss_nxt;
      rcv_r       <= rcv_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cp_iss_r    <= cp_iss_nxt;
      cp_vld_r    <= cp_vld_nxt;
      cp_wa_r     <= cp_wa_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_reg_r <= SIZE_RESET;
      rows_reg_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_COLUMNS: cols_reg_r <= cfg_wdata;
        REG_GRID_ROWS:    rows_reg_r <= cfg_wdata;
        default:          cols_reg_r <= cols_reg_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only ever enters the output register from the finishing state
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("output beat raised outside the finishing state");

  // the grid memory is never read and written in the same cycle
  a_cell_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cell_we && cell_re))
    else $error("grid memory read and written together");

  // scratch rows written by a sweep stay inside the active rows
  a_next_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_we |-> (XW'(nxt_waddr) < rows_eff))
    else $error("scratch row written outside the active rows");

  // the scratch memory is only read while copying back
  a_next_read_copy: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_re |-> (state_r == S_COPY))
    else $error("scratch memory read outside the copy phase");

endmodule

FILE: hw/rtl/lgs_row_ram.sv
// one-port-write, one-port-read row memory with registered read data
// depends on nothing but the width and depth handed down

module lgs_row_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lgs_row_rule.sv
// b3/s23 rule applied across a whole row, one lane per column
// depends on lgs_pkg for counts and the common size width

module lgs_row_rule
  import lgs_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic [MAX_COLUMNS-1:0] up_row,
  input  logic [MAX_COLUMNS-1:0] mid_row,
  input  logic [MAX_COLUMNS-1:0] down_row,
  input  logic [XW-1:0]          cols,
  output logic [MAX_COLUMNS-1:0] new_row
);

  localparam int CIDX_W = $clog2(MAX_COLUMNS);

  logic [XW-1:0]     last_col;
  logic [CIDX_W-1:0] last_idx;

  assign last_col = cols - XW'(1);
  assign last_idx = last_col[CIDX_W-1:0];

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    logic       l_u, l_m, l_d;
    logic       r_u, r_m, r_d;
    logic       at_last;
    logic [3:0] cnt;
    logic       live;

    assign at_last = (XW'(c) == last_col);

    // left neighbour wraps to the last active column
    if (c == 0) begin : g_left_wrap
      assign l_u = up_row[last_idx];
      assign l_m = mid_row[last_idx];
      assign l_d = down_row[last_idx];
    end else begin : g_left
      assign l_u = up_row[c-1];
      assign l_m = mid_row[c-1];
      assign l_d = down_row[c-1];
    end

    // right neighbour wraps to column zero past the last active column
    if (c == MAX_COLUMNS - 1) begin : g_right_wrap
      assign r_u = up_row[0];
      assign r_m = mid_row[0];
      assign r_d = down_row[0];
    end else begin : g_right
      assign r_u = at_last ? up_row[0]   : up_row[c+1];
      assign r_m = at_last ? mid_row[0]  : mid_row[c+1];
      assign r_d = at_last ? down_row[0] : down_row[c+1];
    end

    assign cnt = 4'(l_u) + 4'(up_row[c])   + 4'(r_u)
               + 4'(l_m) + 4'(mid_row[c])  + 4'(r_m)
               + 4'(l_d) + 4'(down_row[c]) + 4'(r_d);

    assign live = mid_row[c] ? ((cnt == KEEP_COUNT_LOW) || (cnt == KEEP_COUNT_HIGH))
                             : (cnt == BIRTH_COUNT);

    // columns outside the active area keep their stored value
    assign new_row[c] = (XW'(c) < cols) ? live : mid_row[c];
  end

endmodule

FILE: sim/tb_life_generation_step.sv
`timescale 1ns / 100ps
// self-checking bench for life_generation_step: directed and random write, read and
// generation beats checked against an in-bench toroidal b3/s23 grid predictor
// depends on lgs_pkg and life_generation_step

module tb_life_generation_step;
  import lgs_pkg::*;

  localparam int COLS_MAX = DEF_MAX_COLUMNS;
  localparam int ROWS_MAX = DEF_MAX_ROWS;
  // the package names no code for the spare mode
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int REPORT_LIMIT     = 10;
  localparam int LONG_HOLD_CYCLES = 250;
  // quiet time after the last result, sized from a generation on the largest grid
  localparam int DRAIN_CYCLES     = 2 * ROWS_MAX + 16;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  lgs_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lgs_out_t          out_data;
  logic              cfg_we    = 1'b0;
  reg_idx_t          cfg_index = REG_GRID_COLUMNS;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // predicted register contents and grid, all cells dead after reset
  logic [SIZE_W-1:0] column_setting = SIZE_RESET;
  logic [SIZE_W-1:0] row_setting    = SIZE_RESET;
  bit                life_grid [0:ROWS_MAX-1][0:COLS_MAX-1];

  lgs_in_t  pending_items[$];
  lgs_out_t expected_beats[$];
  int       items_queued   = 0;
  int       results_seen   = 0;
  int       mismatch_count = 0;

  // sender burst state and receiver stall pattern state
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_pct    = 0;
  int pattern_left = 0;
  int hold_left    = 0;
  int holds_done   = 0;

  life_generation_step u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // size register clamped to the legal range
  function automatic int active_size(logic [SIZE_W-1:0] setting, int top);
    if (setting < SIZE_MIN) return int'(SIZE_MIN);
    if (setting > top) return top;
    return int'(setting);
  endfunction

  // one generation over the active area, neighbourhood counted with the centre,
  // wrapping at the active edges; cells outside the active area are left alone
  function automatic void advance_generation(int cols, int rows);
    bit fresh [0:ROWS_MAX-1][0:COLS_MAX-1];
    int count;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        count = 0;
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            count += life_grid[(r + rows - 1 + dr) % rows][(c + cols - 1 + dc) % cols];
          end
        end
        if (life_grid[r][c])
          fresh[r][c] = (count == KEEP_COUNT_LOW) || (count == KEEP_COUNT_HIGH);
        else
          fresh[r][c] = (count == BIRTH_COUNT);
      end
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        life_grid[r][c] = fresh[r][c];
      end
    end
  endfunction

  // applies one beat to the predicted grid and returns the result it should give
  function automatic lgs_out_t predict_life_item(lgs_in_t item);
    lgs_out_t res;
    int       cols;
    int       rows;
    bit       on_grid;
    cols    = active_size(column_setting, COLS_MAX);
    rows    = active_size(row_setting, ROWS_MAX);
    on_grid = (item.cell_column < cols) && (item.cell_row < rows);
    res.read_alive = 1'b0;
    res.done_res   = 1'b1;
    case (item.mode)
      MODE_WRITE: begin
        if (on_grid) life_grid[item.cell_row][item.cell_column] = item.write_alive;
      end
      MODE_READ: begin
        if (on_grid) res.read_alive = life_grid[item.cell_row][item.cell_column];
      end
      MODE_STEP: begin
        advance_generation(cols, rows);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic queue_cell(logic [MODE_W-1:0] mode, int col, int row, bit alive);
    lgs_in_t item;
    item.mode        = mode;
    item.cell_column = col[COL_FIELD_W-1:0];
    item.cell_row    = row[ROW_FIELD_W-1:0];
    item.write_alive = alive;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // only called while the block is idle
  task automatic write_register(reg_idx_t which, logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == REG_GRID_COLUMNS) column_setting = value;
    else row_setting = value;
  endtask

  task automatic wait_until_drained();
    wait (results_seen >= items_queued);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly patterns: a cluster of writes, one or two generations, then reads of the
  // same neighbourhood, all wrapped into the active grid; the rest is noise with any
  // mode and any position, in range or not
  task automatic queue_random_items(int goal);
    int cols;
    int rows;
    int base_c;
    int base_r;
    int start;
    cols  = active_size(column_setting, COLS_MAX);
    rows  = active_size(row_setting, ROWS_MAX);
    start = items_queued;
    while (items_queued - start < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_cell(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
                   1'($urandom_range(0, 1)));
      end else begin
        base_c = $urandom_range(0, cols - 1);
        base_r = $urandom_range(0, rows - 1);
        repeat ($urandom_range(3, 8)) begin
          queue_cell(MODE_WRITE, (base_c + cols + $urandom_range(0, 4) - 2) % cols,
                     (base_r + rows + $urandom_range(0, 4) - 2) % rows,
                     $urandom_range(0, 3) != 0);
        end
        // position and value bits of a generation beat are don't-care
        repeat ($urandom_range(1, 2)) begin
          queue_cell(MODE_STEP, $urandom_range(0, 127), $urandom_range(0, 127),
                     1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(3, 6)) begin
          queue_cell(MODE_READ, (base_c + cols + $urandom_range(0, 4) - 2) % cols,
                     (base_r + rows + $urandom_range(0, 4) - 2) % rows,
                     1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // sender: offers beats from the pending queue in bursts with random gaps, holding
  // each beat until it is taken; the prediction is made at acceptance
  always @(posedge clk) begin
    lgs_in_t next_data;
    logic    next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_data  = in_data;
      if (in_valid && !in_stall) begin
        expected_beats.push_back(predict_life_item(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          next_data  = pending_items.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          // end of a burst: a third of the time no gap at all
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // receiver: stall pattern with its own segments of random density, plus two long
  // hold-offs while plenty is still pending, so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && pending_items.size() > 8 &&
                 results_seen >= 5 + 30 * holds_done) begin
      hold_left = LONG_HOLD_CYCLES;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        pattern_left--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result check, field by field against the oldest expectation
  always @(posedge clk) begin
    lgs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing expected: read_alive %0b done_res %0b",
                                out_data.read_alive, out_data.done_res));
      end else begin
        want = expected_beats.pop_front();
        if (out_data.read_alive !== want.read_alive)
          note_mismatch($sformatf("read_alive expected %0b got %0b",
                                  want.read_alive, out_data.read_alive));
        if (out_data.done_res !== want.done_res)
          note_mismatch($sformatf("done_res expected %0b got %0b",
                                  want.done_res, out_data.done_res));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset size 100 x 100: corners, out-of-range positions, the spare mode
    queue_cell(MODE_WRITE, 0, 0, 1'b1);
    queue_cell(MODE_READ, 0, 0, 1'b0);
    queue_cell(MODE_WRITE, 99, 99, 1'b1);
    queue_cell(MODE_READ, 99, 99, 1'b0);
    // column past the active edge: write dropped, read gives dead
    queue_cell(MODE_WRITE, 100, 5, 1'b1);
    queue_cell(MODE_READ, 100, 5, 1'b0);
    // row past the active edge, then the far corner of the field range
    queue_cell(MODE_WRITE, 5, 127, 1'b1);
    queue_cell(MODE_READ, 127, 127, 1'b0);
    // spare mode with every field bit set changes nothing
    queue_cell(MODE_UNUSED, 127, 127, 1'b1);
    queue_cell(MODE_READ, 0, 0, 1'b0);
    queue_cell(MODE_WRITE, 99, 99, 1'b0);
    queue_cell(MODE_READ, 99, 99, 1'b0);
    // blinker lying across the column wrap: turns vertical across the row wrap
    queue_cell(MODE_WRITE, 99, 0, 1'b1);
    queue_cell(MODE_WRITE, 1, 0, 1'b1);
    queue_cell(MODE_STEP, 0, 0, 1'b0);
    queue_cell(MODE_READ, 0, 99, 1'b0);
    queue_cell(MODE_READ, 0, 1, 1'b0);
    queue_cell(MODE_READ, 99, 0, 1'b0);
    // and back, with don't-care bits set on the generation beat
    queue_cell(MODE_STEP, 127, 127, 1'b1);
    queue_cell(MODE_READ, 99, 0, 1'b0);
    wait_until_drained();

    // sizes below and above the legal range clamp to 3 and 128
    write_register(REG_GRID_COLUMNS, 8'd0);
    write_register(REG_GRID_ROWS, 8'd255);
    queue_random_items(12);
    wait_until_drained();

    // smallest grid, every neighbour wraps onto the same cells
    write_register(REG_GRID_COLUMNS, 8'd3);
    write_register(REG_GRID_ROWS, 8'd3);
    queue_random_items(12);
    wait_until_drained();

    // largest grid: a cell kept outside the shrunk area shows up again
    write_register(REG_GRID_COLUMNS, 8'd128);
    write_register(REG_GRID_ROWS, 8'd128);
    queue_cell(MODE_READ, 99, 0, 1'b0);
    queue_random_items(12);
    wait_until_drained();

    write_register(REG_GRID_COLUMNS, 8'd255);
    write_register(REG_GRID_ROWS, 8'd1);
    queue_random_items(12);
    wait_until_drained();

    write_register(REG_GRID_COLUMNS, SIZE_W'($urandom_range(3, 24)));
    write_register(REG_GRID_ROWS, SIZE_W'($urandom_range(3, 24)));
    queue_random_items(12);
    wait_until_drained();

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
